// ----- rtl/ste_pkg.sv -----
// Shared types and constants for the sample tangent estimator.
package ste_pkg;

    localparam int VW   = 32;
    localparam int MAX  = 64;
    localparam int IDXW = $clog2(MAX);
    localparam int CNTW = IDXW + 1;
    localparam int NCH  = 6;
    localparam int SPW  = VW + 3;
    localparam int PMW  = VW + 2;

    localparam logic [1:0] CFG_USE_POSITION  = 2'd0;
    localparam logic [1:0] CFG_USE_ANGLES    = 2'd1;
    localparam logic [1:0] CFG_TANGENT_SCALE = 2'd2;
    localparam logic [1:0] CFG_CLOSURE_TOL   = 2'd3;

    typedef struct packed {
        logic                 last_sample;
        logic signed [VW-1:0] ang_r;
        logic signed [VW-1:0] ang_p;
        logic signed [VW-1:0] ang_h;
        logic signed [VW-1:0] pos_z;
        logic signed [VW-1:0] pos_y;
        logic signed [VW-1:0] pos_x;
        logic [VW-1:0]        sample_time;
    } samp_t;

    typedef struct packed {
        logic [IDXW-1:0]      sample_index;
        logic signed [VW-1:0] tan_x;
        logic signed [VW-1:0] tan_y;
        logic signed [VW-1:0] tan_z;
        logic signed [VW-1:0] tan_h;
        logic signed [VW-1:0] tan_p;
        logic signed [VW-1:0] tan_r;
        logic                 path_closed;
        logic                 span_zero;
        logic                 too_few;
        logic                 overflowed;
        logic                 last_result;
    } tang_t;

    typedef struct packed {
        logic [VW-1:0]             t;
        logic [NCH-1:0][VW-1:0]    v;
    } row_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_CLOSE,
        S_ROW,
        S_SPAN,
        S_MUL,
        S_CHK,
        S_DIV,
        S_FIN,
        S_EMIT
    } state_t;

endpackage

// ----- rtl/sample_tangent_estimator_unit.sv -----
// Sample tangent estimator: sample store, closure test and shared multiply-divide sequencer.
//
// Samples are stored at one per cycle while the block is idle, until the transaction marked
// last_sample. The block then reads the first, second and two final samples and decides
// closure. For each stored sample it reads the two neighbor rows, forms the span and runs six
// tangents through one shared 32x32 multiplier and one restoring divider that retires one
// quotient bit per cycle (multiply, check, 32 divide steps and finish). A tangent of a
// disabled channel, or one with a zero difference, scale or span, skips the divide steps and
// finish and gives zero. A saturating tangent skips the divide steps. A finished result waits
// in the emit state while the previous one is still unaccepted. No sample is taken while a
// run is in progress.
module sample_tangent_estimator_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              samp_valid,
    output logic              samp_ready,
    input  ste_pkg::samp_t    samp_data,
    output logic              tang_valid,
    input  logic              tang_ready,
    output ste_pkg::tang_t    tang_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    ste_pkg::state_t state_reg, state_next;

    logic                        use_pos_reg;
    logic                        use_ang_reg;
    logic signed [31:0]          scale_reg;
    logic [15:0]                 tol_reg;

    ste_pkg::row_t               mem [ste_pkg::MAX];
    ste_pkg::row_t               rd_row_reg;
    logic [ste_pkg::IDXW-1:0]    rd_addr;

    logic [ste_pkg::CNTW-1:0]    count_reg;
    logic                        ovf_reg;
    logic                        few_reg;
    logic [2:0]                  fcnt_reg;

    logic [ste_pkg::VW-1:0]      t0_reg, t1_reg, tn2_reg, tn1_reg;
    logic [ste_pkg::NCH-1:0][ste_pkg::VW-1:0] first_reg, last_reg;
    logic [ste_pkg::NCH-1:0][ste_pkg::VW-1:0] hi_reg, lo_reg;
    logic [ste_pkg::VW-1:0]      hi_t_reg, lo_t_reg;
    logic                        closed_reg;
    logic [ste_pkg::IDXW-1:0]    idx_reg;

    logic [ste_pkg::PMW-1:0]     pm_reg;
    logic                        sneg_reg;
    logic                        szero_reg;

    logic [2:0]                  ch_reg;
    logic [2*ste_pkg::VW-1:0]    prod_reg;
    logic                        neg_reg;
    logic                        skip_reg;
    logic [ste_pkg::SPW-1:0]     rem_reg;
    logic [ste_pkg::VW-1:0]      lo_sh_reg;
    logic [ste_pkg::VW-1:0]      q_reg;
    logic [ste_pkg::IDXW-1:0]    bit_reg;
    logic [ste_pkg::NCH-1:0][ste_pkg::VW-1:0] tan_reg;

    logic                        tang_valid_reg;
    ste_pkg::tang_t              tang_data_reg;

    logic                        samp_acc;
    logic                        has_room;
    logic [ste_pkg::CNTW-1:0]    n_new;
    logic [ste_pkg::IDXW-1:0]    last_idx, prev_idx;
    logic                        is_first, is_last;
    logic [ste_pkg::IDXW-1:0]    hi_idx, lo_idx;
    logic                        emit_ok;

    logic signed [ste_pkg::SPW-1:0] d_hi, d_lo, span;
    logic [ste_pkg::PMW-1:0]     span_mag;

    logic signed [ste_pkg::VW:0] diff;
    logic [ste_pkg::VW-1:0]      dm, sm;
    logic                        ch_en;

    logic [ste_pkg::SPW-1:0]     r2;
    logic                        r2_ge;
    logic [ste_pkg::VW-1:0]      lim, sat_q;

    logic                        match_pos, match_ang;

    function automatic logic ends_match(input logic [ste_pkg::VW-1:0] a0,
                                        input logic [ste_pkg::VW-1:0] a1,
                                        input logic [ste_pkg::VW-1:0] a2,
                                        input logic [ste_pkg::VW-1:0] b0,
                                        input logic [ste_pkg::VW-1:0] b1,
                                        input logic [ste_pkg::VW-1:0] b2,
                                        input logic [15:0] tol);
        logic signed [ste_pkg::VW:0] d0, d1, d2;
        logic [ste_pkg::VW:0] m0, m1, m2;
        d0 = $signed({a0[ste_pkg::VW-1], a0}) - $signed({b0[ste_pkg::VW-1], b0});
        d1 = $signed({a1[ste_pkg::VW-1], a1}) - $signed({b1[ste_pkg::VW-1], b1});
        d2 = $signed({a2[ste_pkg::VW-1], a2}) - $signed({b2[ste_pkg::VW-1], b2});
        m0 = d0[ste_pkg::VW] ? -d0 : d0;
        m1 = d1[ste_pkg::VW] ? -d1 : d1;
        m2 = d2[ste_pkg::VW] ? -d2 : d2;
        return (m0 < {{(ste_pkg::VW+1-16){1'b0}}, tol}) &&
               (m1 < {{(ste_pkg::VW+1-16){1'b0}}, tol}) &&
               (m2 < {{(ste_pkg::VW+1-16){1'b0}}, tol});
    endfunction

    assign samp_ready = (state_reg == ste_pkg::S_IDLE);
    assign samp_acc   = samp_valid && samp_ready;
    assign cfg_ready  = 1'b1;
    assign tang_valid = tang_valid_reg;
    assign tang_data  = tang_data_reg;

    assign has_room = (count_reg < ste_pkg::CNTW'(ste_pkg::MAX));
    assign n_new    = count_reg + {{(ste_pkg::CNTW-1){1'b0}}, has_room};
    assign last_idx = ste_pkg::IDXW'(count_reg - ste_pkg::CNTW'(1));
    assign prev_idx = ste_pkg::IDXW'(count_reg - ste_pkg::CNTW'(2));
    assign is_first = (idx_reg == '0);
    assign is_last  = (idx_reg == last_idx);
    assign emit_ok  = !tang_valid_reg || tang_ready;

    always_comb
    begin
        if (!is_first && !is_last)
        begin
            hi_idx = idx_reg + ste_pkg::IDXW'(1);
            lo_idx = idx_reg - ste_pkg::IDXW'(1);
        end
        else if (closed_reg)
        begin
            hi_idx = ste_pkg::IDXW'(1);
            lo_idx = prev_idx;
        end
        else if (is_first)
        begin
            hi_idx = ste_pkg::IDXW'(1);
            lo_idx = '0;
        end
        else
        begin
            hi_idx = last_idx;
            lo_idx = prev_idx;
        end
    end

    always_comb
    begin
        rd_addr = hi_idx;
        if (state_reg == ste_pkg::S_FETCH)
        begin
            unique case (fcnt_reg[1:0])
                2'd0: rd_addr = '0;
                2'd1: rd_addr = ste_pkg::IDXW'(1);
                2'd2: rd_addr = prev_idx;
                2'd3: rd_addr = last_idx;
            endcase
        end
        else if (fcnt_reg != 3'd0)
        begin
            rd_addr = lo_idx;
        end
    end

    always_comb
    begin
        d_hi = $signed({3'b000, hi_t_reg}) - $signed({3'b000, lo_t_reg});
        d_lo = $signed({3'b000, t1_reg}) - $signed({3'b000, t0_reg});
        if (!is_first && !is_last)
        begin
            span = d_hi;
        end
        else if (closed_reg)
        begin
            span = d_lo + ($signed({3'b000, tn1_reg}) - $signed({3'b000, tn2_reg}));
        end
        else if (is_first)
        begin
            span = d_lo <<< 1;
        end
        else
        begin
            span = ($signed({3'b000, tn1_reg}) - $signed({3'b000, tn2_reg})) <<< 1;
        end
        span_mag = span[ste_pkg::SPW-1] ? ste_pkg::PMW'(-span) : ste_pkg::PMW'(span);
    end

    always_comb
    begin
        diff = $signed({hi_reg[ch_reg][ste_pkg::VW-1], hi_reg[ch_reg]}) -
               $signed({lo_reg[ch_reg][ste_pkg::VW-1], lo_reg[ch_reg]});
        dm   = diff[ste_pkg::VW] ? ste_pkg::VW'(-diff) : ste_pkg::VW'(diff);
        sm   = scale_reg[31] ? ste_pkg::VW'(-scale_reg) : ste_pkg::VW'(scale_reg);
        ch_en = (ch_reg < 3'd3) ? use_pos_reg : use_ang_reg;
    end

    assign r2    = {rem_reg[ste_pkg::SPW-2:0], lo_sh_reg[ste_pkg::VW-1]};
    assign r2_ge = (r2 >= {1'b0, pm_reg});
    assign lim   = neg_reg ? {1'b1, {(ste_pkg::VW-1){1'b0}}} : {1'b0, {(ste_pkg::VW-1){1'b1}}};
    assign sat_q = (q_reg > lim) ? lim : q_reg;

    assign match_pos = ends_match(first_reg[0], first_reg[1], first_reg[2],
                                  last_reg[0], last_reg[1], last_reg[2], tol_reg);
    assign match_ang = ends_match(first_reg[3], first_reg[4], first_reg[5],
                                  last_reg[3], last_reg[4], last_reg[5], tol_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ste_pkg::S_IDLE:
            begin
                if (samp_acc && samp_data.last_sample)
                begin
                    state_next = (n_new < ste_pkg::CNTW'(2)) ? ste_pkg::S_EMIT
                                                             : ste_pkg::S_FETCH;
                end
            end
            ste_pkg::S_FETCH:
            begin
                if (fcnt_reg == 3'd4)
                begin
                    state_next = ste_pkg::S_CLOSE;
                end
            end
            ste_pkg::S_CLOSE: state_next = ste_pkg::S_ROW;
            ste_pkg::S_ROW:
            begin
                if (fcnt_reg == 3'd2)
                begin
                    state_next = ste_pkg::S_SPAN;
                end
            end
            ste_pkg::S_SPAN: state_next = ste_pkg::S_MUL;
            ste_pkg::S_MUL:  state_next = ste_pkg::S_CHK;
            ste_pkg::S_CHK:
            begin
                if (skip_reg)
                begin
                    state_next = (ch_reg == 3'd5) ? ste_pkg::S_EMIT : ste_pkg::S_MUL;
                end
                else if ({2'b00, prod_reg[2*ste_pkg::VW-1:ste_pkg::VW]} >= pm_reg)
                begin
                    state_next = ste_pkg::S_FIN;
                end
                else
                begin
                    state_next = ste_pkg::S_DIV;
                end
            end
            ste_pkg::S_DIV:
            begin
                if (bit_reg == ste_pkg::IDXW'(ste_pkg::VW-1))
                begin
                    state_next = ste_pkg::S_FIN;
                end
            end
            ste_pkg::S_FIN:
            begin
                state_next = (ch_reg == 3'd5) ? ste_pkg::S_EMIT : ste_pkg::S_MUL;
            end
            ste_pkg::S_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = (few_reg || is_last) ? ste_pkg::S_IDLE : ste_pkg::S_ROW;
                end
            end
            default: state_next = ste_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ste_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samp_acc && has_room)
        begin
            mem[count_reg[ste_pkg::IDXW-1:0]] <= '{t: samp_data.sample_time,
                v: {samp_data.ang_r, samp_data.ang_p, samp_data.ang_h,
                    samp_data.pos_z, samp_data.pos_y, samp_data.pos_x}};
        end
        rd_row_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_pos_reg <= 1'b1;
            use_ang_reg <= 1'b0;
            scale_reg   <= 32'sd65536;
            tol_reg     <= 16'd66;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ste_pkg::CFG_USE_POSITION:  use_pos_reg <= cfg_data[0];
                ste_pkg::CFG_USE_ANGLES:    use_ang_reg <= cfg_data[0];
                ste_pkg::CFG_TANGENT_SCALE: scale_reg   <= cfg_data;
                ste_pkg::CFG_CLOSURE_TOL:   tol_reg     <= cfg_data[15:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            few_reg        <= 1'b0;
            fcnt_reg       <= '0;
            tang_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ste_pkg::S_EMIT && emit_ok)
            begin
                tang_valid_reg <= 1'b1;
            end
            else if (tang_ready)
            begin
                tang_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ste_pkg::S_IDLE:
                begin
                    fcnt_reg <= '0;
                    if (samp_acc)
                    begin
                        count_reg <= n_new;
                        if (!has_room)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        few_reg <= samp_data.last_sample && (n_new < ste_pkg::CNTW'(2));
                    end
                end
                ste_pkg::S_FETCH, ste_pkg::S_ROW:
                begin
                    fcnt_reg <= (state_next == state_reg) ? fcnt_reg + 3'd1 : 3'd0;
                end
                ste_pkg::S_EMIT:
                begin
                    if (emit_ok && (few_reg || is_last))
                    begin
                        count_reg <= '0;
                        ovf_reg   <= 1'b0;
                        few_reg   <= 1'b0;
                    end
                end
                default:
                begin
                    fcnt_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ste_pkg::S_IDLE:
            begin
                idx_reg <= '0;
            end
            ste_pkg::S_FETCH:
            begin
                unique case (fcnt_reg)
                    3'd1:
                    begin
                        t0_reg    <= rd_row_reg.t;
                        first_reg <= rd_row_reg.v;
                    end
                    3'd2: t1_reg  <= rd_row_reg.t;
                    3'd3: tn2_reg <= rd_row_reg.t;
                    3'd4:
                    begin
                        tn1_reg  <= rd_row_reg.t;
                        last_reg <= rd_row_reg.v;
                    end
                    default: ;
                endcase
            end
            ste_pkg::S_CLOSE:
            begin
                closed_reg <= use_pos_reg ? match_pos : (use_ang_reg && match_ang);
            end
            ste_pkg::S_ROW:
            begin
                if (fcnt_reg == 3'd1)
                begin
                    hi_reg   <= rd_row_reg.v;
                    hi_t_reg <= rd_row_reg.t;
                end
                else if (fcnt_reg == 3'd2)
                begin
                    lo_reg   <= rd_row_reg.v;
                    lo_t_reg <= rd_row_reg.t;
                end
            end
            ste_pkg::S_SPAN:
            begin
                pm_reg    <= span_mag;
                sneg_reg  <= span[ste_pkg::SPW-1];
                szero_reg <= (span == '0);
                ch_reg    <= '0;
            end
            ste_pkg::S_MUL:
            begin
                prod_reg <= dm * sm;
                neg_reg  <= diff[ste_pkg::VW] ^ scale_reg[31] ^ sneg_reg;
                skip_reg <= !ch_en || (diff == '0) || (scale_reg == '0) || szero_reg;
            end
            ste_pkg::S_CHK:
            begin
                rem_reg   <= {3'b000, prod_reg[2*ste_pkg::VW-1:ste_pkg::VW]};
                lo_sh_reg <= prod_reg[ste_pkg::VW-1:0];
                bit_reg   <= '0;
                q_reg     <= '1;
                if (skip_reg)
                begin
                    tan_reg[ch_reg] <= '0;
                    ch_reg          <= ch_reg + 3'd1;
                end
            end
            ste_pkg::S_DIV:
            begin
                rem_reg   <= r2_ge ? r2 - {1'b0, pm_reg} : r2;
                q_reg     <= {q_reg[ste_pkg::VW-2:0], r2_ge};
                lo_sh_reg <= {lo_sh_reg[ste_pkg::VW-2:0], 1'b0};
                bit_reg   <= bit_reg + ste_pkg::IDXW'(1);
            end
            ste_pkg::S_FIN:
            begin
                tan_reg[ch_reg] <= neg_reg ? -sat_q : sat_q;
                ch_reg          <= ch_reg + 3'd1;
            end
            ste_pkg::S_EMIT:
            begin
                if (emit_ok)
                begin
                    tang_data_reg.sample_index <= few_reg ? '0 : idx_reg;
                    tang_data_reg.tan_x        <= few_reg ? '0 : tan_reg[0];
                    tang_data_reg.tan_y        <= few_reg ? '0 : tan_reg[1];
                    tang_data_reg.tan_z        <= few_reg ? '0 : tan_reg[2];
                    tang_data_reg.tan_h        <= few_reg ? '0 : tan_reg[3];
                    tang_data_reg.tan_p        <= few_reg ? '0 : tan_reg[4];
                    tang_data_reg.tan_r        <= few_reg ? '0 : tan_reg[5];
                    tang_data_reg.path_closed  <= !few_reg && closed_reg;
                    tang_data_reg.span_zero    <= !few_reg && szero_reg;
                    tang_data_reg.too_few      <= few_reg;
                    tang_data_reg.overflowed   <= ovf_reg;
                    tang_data_reg.last_result  <= few_reg || is_last;
                    idx_reg                    <= idx_reg + ste_pkg::IDXW'(1);
                end
            end
            default: ;
        endcase
    end

endmodule
